/* hdl/cft_pkg.sv */
// Shared constants and types of the CSV field tokenizer.
`default_nettype none
package cft_pkg;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] PRINT_LOW      = 8'h20;
   localparam logic [7:0] PRINT_HIGH     = 8'h7E;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   localparam logic [1:0] CAUSE_SEP   = 2'd0;
   localparam logic [1:0] CAUSE_LINE  = 2'd1;
   localparam logic [1:0] CAUSE_OTHER = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] content;
      logic       was_quoted;
      logic [1:0] end_cause;
   } result_type;

   // One queue entry holds every result that a single byte causes.
   typedef struct packed {
      logic       two;
      result_type res_a;
      result_type res_b;
   } entry_type;

endpackage
`default_nettype wire

/* hdl/cft_ifs.sv */
// Channel interfaces of the CSV field tokenizer.
`default_nettype none
interface cft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface cft_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] content;
   logic       was_quoted;
   logic [1:0] end_cause;
   logic       last;
   modport source (output valid, output kind, output content, output was_quoted,
                   output end_cause, output last, input ready);
   modport sink (input valid, input kind, input content, input was_quoted,
                 input end_cause, input last, output ready);
endinterface

interface cft_csr_if;
   logic valid;
   logic ready;
   logic semicolon_mode;
   modport source (output valid, output semicolon_mode, input ready);
   modport sink (input valid, input semicolon_mode, output ready);
endinterface
`default_nettype wire

/* hdl/cft_front.sv */
// Front end: accepts text bytes, runs the field state machine, queues results.
`default_nettype none
module cft_front
   import cft_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   cft_req_if.sink    req_ch,
   cft_csr_if.sink    csr_ch,
   input  wire        queue_full,
   output logic       push,
   output entry_type  push_data
);

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_PLAIN  = 2'd1;
   localparam logic [1:0] PH_QUOTED = 2'd2;
   localparam logic [1:0] PH_AFTERQ = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic       quoted_ff, quoted_in;
   logic       mode_ff;
   logic       fire, has_result;
   logic [7:0] c;
   logic       line_end, mode_sep, sep, printable, start_none, start_quote;
   entry_type  ent;

   assign c           = req_ch.text_byte;
   assign fire        = req_ch.valid && !queue_full;
   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;

   assign line_end    = (c == CHAR_NUL) || (c == CHAR_NEWLINE);
   assign mode_sep    = mode_ff ? (c == CHAR_SEMICOLON) : (c == CHAR_COMMA);
   assign sep         = (c == CHAR_TAB) || mode_sep;
   assign printable   = (c >= PRINT_LOW) && (c <= PRINT_HIGH);
   assign start_none  = !printable || mode_sep;
   assign start_quote = (c == CHAR_QUOTE);

   always_comb begin
      phase_in   = phase_ff;
      quoted_in  = quoted_ff;
      has_result = 1'b0;
      ent        = '0;
      unique case (phase_ff)
         PH_START: begin
            quoted_in = 1'b0;
            if (start_none) begin
               has_result     = 1'b1;
               ent.res_a.kind = KIND_NONE;
               phase_in       = PH_START;
            end else if (start_quote) begin
               quoted_in = 1'b1;
               phase_in  = PH_QUOTED;
            end else begin
               has_result        = 1'b1;
               ent.res_a.kind    = KIND_BYTE;
               ent.res_a.content = c;
               phase_in          = PH_PLAIN;
            end
         end
         PH_PLAIN, PH_QUOTED: begin
            has_result = 1'b1;
            if (line_end) begin
               ent.res_a.kind       = KIND_END;
               ent.res_a.was_quoted = quoted_ff;
               ent.res_a.end_cause  = CAUSE_LINE;
               phase_in             = PH_START;
               quoted_in            = 1'b0;
            end else if ((phase_ff == PH_PLAIN) && sep) begin
               ent.res_a.kind       = KIND_END;
               ent.res_a.was_quoted = quoted_ff;
               ent.res_a.end_cause  = CAUSE_SEP;
               phase_in             = PH_START;
               quoted_in            = 1'b0;
            end else if ((phase_ff == PH_QUOTED) && start_quote) begin
               has_result = 1'b0;
               phase_in   = PH_AFTERQ;
            end else begin
               ent.res_a.kind       = KIND_BYTE;
               ent.res_a.content    = c;
               ent.res_a.was_quoted = quoted_ff;
            end
         end
         PH_AFTERQ: begin
            has_result           = 1'b1;
            ent.res_a.kind       = KIND_END;
            ent.res_a.was_quoted = quoted_ff;
            phase_in             = PH_START;
            quoted_in            = 1'b0;
            if (sep) begin
               ent.res_a.end_cause = CAUSE_SEP;
            end else if (line_end) begin
               ent.res_a.end_cause = CAUSE_LINE;
            end else begin
               // The byte after the closing quote also opens the next field.
               ent.res_a.end_cause = CAUSE_OTHER;
               if (start_none) begin
                  ent.two        = 1'b1;
                  ent.res_b.kind = KIND_NONE;
               end else if (start_quote) begin
                  quoted_in = 1'b1;
                  phase_in  = PH_QUOTED;
               end else begin
                  ent.two           = 1'b1;
                  ent.res_b.kind    = KIND_BYTE;
                  ent.res_b.content = c;
                  phase_in          = PH_PLAIN;
               end
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   assign push      = fire && has_result;
   assign push_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         quoted_ff <= 1'b0;
         mode_ff   <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff  <= phase_in;
            quoted_ff <= quoted_in;
         end
         if (csr_ch.valid) begin
            mode_ff <= csr_ch.semicolon_mode;
         end
      end
   end

endmodule
`default_nettype wire

/* hdl/cft_queue.sv */
// Short queue of result entries between the front and back ends.
`default_nettype none
module cft_queue
   import cft_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   input  entry_type  push_data,
   output logic       full,
   input  wire        pop,
   output entry_type  head,
   output logic       empty
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

/* hdl/cft_back.sv */
// Back end: expands queue entries into result items behind an output register.
`default_nettype none
module cft_back
   import cft_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  entry_type  head,
   input  wire        empty,
   output logic       pop,
   cft_rsp_if.source  rsp_ch
);

   logic       rsp_valid_ff;
   logic       sub_ff;
   result_type res_ff;
   logic       last_ff;
   logic       load, take, emit_last;
   result_type emit;

   assign load      = !rsp_valid_ff || rsp_ch.ready;
   assign take      = load && !empty;
   assign emit      = sub_ff ? head.res_b : head.res_a;
   assign emit_last = !(head.two && !sub_ff);
   assign pop       = take && emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !empty;
         end
         if (take) begin
            sub_ff <= !emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff  <= emit;
         last_ff <= emit_last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = res_ff.kind;
   assign rsp_ch.content    = res_ff.content;
   assign rsp_ch.was_quoted = res_ff.was_quoted;
   assign rsp_ch.end_cause  = res_ff.end_cause;
   assign rsp_ch.last       = last_ff;

endmodule
`default_nettype wire

/* hdl/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer.
//
//   Channel   Direction   Carries
//   req_ch    in          one text byte per item
//   rsp_ch    out         kind, content, was_quoted, end_cause, last per item
//   csr_ch    in          semicolon_mode register write
//
// The front end takes one byte per cycle while the four-entry queue has room.
// A byte that causes two results yields two output items; only the second has last set.
// Each result passes through the queue and then the output register before it is offered.
// Synchronous reset clears the field state, the mode register and the queue.
// Either side may stall on its own; the queue absorbs the difference.
`default_nettype none
module csv_field_tokenizer
   import cft_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   cft_req_if.sink    req_ch,
   cft_rsp_if.source  rsp_ch,
   cft_csr_if.sink    csr_ch
);

   logic      push, queue_full, pop, queue_empty;
   entry_type push_data, head;

   cft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   cft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   cft_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the CSV field tokenizer: directed table, then random lines.
`timescale 1ns / 100ps
module tb_top;
   import cft_pkg::*;

   typedef enum logic [1:0] {
      PH_FIELD_START,
      PH_UNQUOTED,
      PH_QUOTED,
      PH_AFTER_QUOTE
   } tok_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] content;
      logic       was_quoted;
      logic [1:0] end_cause;
      logic       last;
   } token_type;

   typedef struct {
      logic [7:0] text;
      int         typed_n;
      token_type  t0;
      token_type  t1;
   } row_type;

   localparam logic [1:0] CAUSE_NONE = 2'd0;
   localparam token_type NO_FIELD_TOKEN = '{kind: KIND_NONE, content: 8'h00, was_quoted: 1'b0,
                                            end_cause: CAUSE_NONE, last: 1'b1};
   localparam int N_PHASES      = 6;
   localparam int PHASE_ITEMS   = 222;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 200;
   localparam int CYCLE_LIMIT   = 1000000;

   logic clock = 1'b0;
   logic reset;

   cft_req_if req_ch();
   cft_rsp_if rsp_ch();
   cft_csr_if csr_ch();

   csv_field_tokenizer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tok_phase_type tok_phase = PH_FIELD_START;
   logic          tok_quoted = 1'b0;
   logic          semicolon_mode_q = 1'b0;
   token_type     new_tokens[$];
   token_type     pending_tokens[$];
   row_type       directed_rows[$];

   int errors = 0;
   int cycles = 0;
   int bytes_sent = 0;
   int lines_sent = 0;
   int mode_writes = 0;
   int results_seen = 0;
   int content_results = 0;
   int end_results = 0;
   int other_cause_results = 0;
   int nofield_results = 0;

   function automatic token_type mk_token(logic [1:0] kind, logic [7:0] content, logic quoted,
                                          logic [1:0] cause, logic last);
      token_type t;
      t.kind = kind;
      t.content = content;
      t.was_quoted = quoted;
      t.end_cause = cause;
      t.last = last;
      return t;
   endfunction

   function automatic logic [7:0] mode_sep_char();
      return semicolon_mode_q ? CHAR_SEMICOLON : CHAR_COMMA;
   endfunction

   function automatic bit is_line_end(logic [7:0] b);
      return b == CHAR_NUL || b == CHAR_NEWLINE;
   endfunction

   function automatic bit is_field_sep(logic [7:0] b);
      return b == CHAR_TAB || b == mode_sep_char();
   endfunction

   function automatic void emit(logic [1:0] kind, logic [7:0] content, logic quoted,
                                logic [1:0] cause);
      new_tokens.push_back(mk_token(kind, content, quoted, cause, 1'b0));
   endfunction

   function automatic void start_field(logic [7:0] b);
      tok_quoted = 1'b0;
      if (b < PRINT_LOW || b > PRINT_HIGH || b == mode_sep_char()) begin
         tok_phase = PH_FIELD_START;
         emit(KIND_NONE, 8'h00, 1'b0, CAUSE_NONE);
      end else if (b == CHAR_QUOTE) begin
         tok_quoted = 1'b1;
         tok_phase = PH_QUOTED;
      end else begin
         tok_phase = PH_UNQUOTED;
         emit(KIND_BYTE, b, 1'b0, CAUSE_NONE);
      end
   endfunction

   function automatic void end_field(logic [1:0] cause);
      emit(KIND_END, 8'h00, tok_quoted, cause);
      tok_phase = PH_FIELD_START;
      tok_quoted = 1'b0;
   endfunction

   function automatic void tokenize(logic [7:0] b);
      token_type t;
      new_tokens.delete();
      case (tok_phase)
         PH_FIELD_START: start_field(b);
         PH_UNQUOTED: begin
            if (is_line_end(b)) end_field(CAUSE_LINE);
            else if (is_field_sep(b)) end_field(CAUSE_SEP);
            else emit(KIND_BYTE, b, tok_quoted, CAUSE_NONE);
         end
         PH_QUOTED: begin
            if (is_line_end(b)) end_field(CAUSE_LINE);
            else if (b == CHAR_QUOTE) tok_phase = PH_AFTER_QUOTE;
            else emit(KIND_BYTE, b, tok_quoted, CAUSE_NONE);
         end
         default: begin
            if (is_field_sep(b)) begin
               end_field(CAUSE_SEP);
            end else if (is_line_end(b)) begin
               end_field(CAUSE_LINE);
            end else begin
               end_field(CAUSE_OTHER);
               start_field(b);
            end
         end
      endcase
      if (new_tokens.size() > 0) begin
         t = new_tokens.pop_back();
         t.last = 1'b1;
         new_tokens.push_back(t);
      end
   endfunction

   function automatic logic [7:0] rand_any();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_printable();
      return 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
   endfunction

   function automatic logic [7:0] plain_first();
      logic [7:0] b;
      do b = rand_printable(); while (b == CHAR_QUOTE || b == mode_sep_char());
      return b;
   endfunction

   function automatic logic [7:0] plain_body();
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 9) == 0) b = semicolon_mode_q ? CHAR_COMMA : CHAR_SEMICOLON;
         else if ($urandom_range(0, 4) == 0) b = rand_any();
         else b = rand_printable();
      end while (is_field_sep(b) || is_line_end(b));
      return b;
   endfunction

   function automatic logic [7:0] quoted_body();
      logic [7:0] b;
      do begin
         case ($urandom_range(0, 19))
            0: b = CHAR_TAB;
            1: b = CHAR_COMMA;
            2: b = CHAR_SEMICOLON;
            3, 4, 5: b = rand_any();
            default: b = rand_printable();
         endcase
      end while (b == CHAR_QUOTE || is_line_end(b));
      return b;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void flag_mismatch(string field, int want, int got);
      errors++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
   endfunction

   task automatic feed_byte(input logic [7:0] b, input bit burst, input int typed_n = -1,
                            input token_type t0 = '0, input token_type t1 = '0);
      int gap;
      req_ch.text_byte <= b;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      tokenize(b);
      if (typed_n < 0) begin
         foreach (new_tokens[i]) pending_tokens.push_back(new_tokens[i]);
      end else begin
         if (typed_n > 0) pending_tokens.push_back(t0);
         if (typed_n > 1) pending_tokens.push_back(t1);
      end
      bytes_sent++;
      gap = burst ? 0 : idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic feed_line(input bit burst);
      int n_fields;
      int r;
      bit glued;
      lines_sent++;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 12)) feed_byte(rand_any(), burst);
         return;
      end
      n_fields = $urandom_range(1, 6);
      for (int f = 0; f < n_fields; f++) begin
         glued = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 45) begin
            feed_byte(plain_first(), burst);
            repeat ($urandom_range(0, 7)) feed_byte(plain_body(), burst);
         end else if (r < 80) begin
            feed_byte(CHAR_QUOTE, burst);
            repeat ($urandom_range(0, 8)) feed_byte(quoted_body(), burst);
            feed_byte(CHAR_QUOTE, burst);
            glued = $urandom_range(0, 99) < 15;
         end
         if (f < n_fields - 1 && !glued)
            feed_byte($urandom_range(0, 1) ? CHAR_TAB : mode_sep_char(), burst);
      end
      if ($urandom_range(0, 9) != 0)
         feed_byte($urandom_range(0, 1) ? CHAR_NEWLINE : CHAR_NUL, burst);
   endtask

   task automatic wait_idle();
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_ch.semicolon_mode <= m;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      semicolon_mode_q = m;
      mode_writes++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycles,
                  pending_tokens.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      token_type want;
      int hold_left;
      int steady_left;
      int holds_done;
      int r;
      hold_left = 0;
      steady_left = 0;
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               results_seen++;
               case (rsp_ch.kind)
                  KIND_BYTE: content_results++;
                  KIND_END: begin
                     end_results++;
                     if (rsp_ch.end_cause == CAUSE_OTHER) other_cause_results++;
                  end
                  default: nofield_results++;
               endcase
               if (pending_tokens.size() == 0) begin
                  errors++;
                  $error("unexpected item: kind %0d content 0x%02h", rsp_ch.kind,
                         rsp_ch.content);
               end else begin
                  want = pending_tokens.pop_front();
                  if (rsp_ch.kind !== want.kind)
                     flag_mismatch("kind", want.kind, rsp_ch.kind);
                  if (rsp_ch.content !== want.content)
                     flag_mismatch("content", want.content, rsp_ch.content);
                  if (rsp_ch.was_quoted !== want.was_quoted)
                     flag_mismatch("was_quoted", want.was_quoted, rsp_ch.was_quoted);
                  if (rsp_ch.end_cause !== want.end_cause)
                     flag_mismatch("end_cause", want.end_cause, rsp_ch.end_cause);
                  if (rsp_ch.last !== want.last)
                     flag_mismatch("last", want.last, rsp_ch.last);
               end
            end
            if (hold_left == 0 && holds_done < 2 &&
                results_seen >= (holds_done == 0 ? 300 : 900)) begin
               holds_done++;
               hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_ch.ready <= 1'b0;
            end else if (steady_left > 0) begin
               steady_left--;
               rsp_ch.ready <= 1'b1;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 3) begin
                  steady_left = $urandom_range(30, 80);
                  rsp_ch.ready <= 1'b1;
               end else if (r < 75) begin
                  rsp_ch.ready <= 1'b1;
               end else if (r < 95) begin
                  hold_left = $urandom_range(0, 2);
                  rsp_ch.ready <= 1'b0;
               end else begin
                  hold_left = $urandom_range(9, 39);
                  rsp_ch.ready <= 1'b0;
               end
            end
         end
      end
   end

   initial begin
      int phase_start;
      bit paused;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.text_byte <= 8'h00;
      csr_ch.valid <= 1'b0;
      csr_ch.semicolon_mode <= 1'b0;
      paused = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_rows.push_back('{CHAR_NUL, 1, NO_FIELD_TOKEN, '0});
      directed_rows.push_back('{8'hFF, 1, NO_FIELD_TOKEN, '0});
      directed_rows.push_back('{CHAR_NEWLINE, 1, NO_FIELD_TOKEN, '0});
      directed_rows.push_back('{CHAR_TAB, 1, NO_FIELD_TOKEN, '0});
      directed_rows.push_back('{CHAR_COMMA, 1, NO_FIELD_TOKEN, '0});
      directed_rows.push_back('{PRINT_HIGH, -1, '0, '0});
      directed_rows.push_back('{CHAR_SEMICOLON, -1, '0, '0});
      directed_rows.push_back('{8'hFF, 1, mk_token(KIND_BYTE, 8'hFF, 1'b0, CAUSE_NONE, 1'b1),
                                '0});
      directed_rows.push_back('{CHAR_COMMA, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_COMMA, -1, '0, '0});
      directed_rows.push_back('{CHAR_TAB, -1, '0, '0});
      directed_rows.push_back('{PRINT_LOW, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{8'h78, -1, '0, '0});
      directed_rows.push_back('{CHAR_NEWLINE, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_NUL, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_COMMA, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{CHAR_QUOTE, -1, '0, '0});
      directed_rows.push_back('{8'h7F, -1, '0, '0});
      foreach (directed_rows[i])
         feed_byte(directed_rows[i].text, 1'b0, directed_rows[i].typed_n,
                   directed_rows[i].t0, directed_rows[i].t1);

      for (int p = 0; p < N_PHASES; p++) begin
         req_ch.valid <= 1'b0;
         wait_idle();
         if (p == 0) write_mode(1'b1);
         else if (p == 1) write_mode(1'b0);
         else write_mode(1'($urandom_range(0, 1)));
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_ITEMS) begin
            if (p == 2 && !paused && bytes_sent - phase_start >= 100) begin
               paused = 1'b1;
               req_ch.valid <= 1'b0;
               wait_idle();
            end
            feed_line($urandom_range(0, 4) == 0);
         end
      end

      req_ch.valid <= 1'b0;
      wait_idle();
      $display("Sent %0d bytes in %0d random lines across %0d mode writes.", bytes_sent,
               lines_sent, mode_writes);
      $display("Checked %0d content, %0d field-end (%0d after a closing quote), %0d no-field.",
               content_results, end_results, other_cause_results, nofield_results);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
